[design/differential_drive_mixer_macros.svh]
// Assertion macros for the differential drive mixer.
`ifndef DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DDM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define DDM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[design/dmx_pkg.sv]
// Shared types and constants of the differential drive mixer.
`timescale 1ns / 1ps

package dmx_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  MAX_SPEED_RESET = 8'd255;
    localparam logic [7:0]  MIN_DUTY_RESET  = 8'd80;
    localparam logic [15:0] DEADBAND_Q15    = 16'd327;
    localparam logic [16:0] FULL_Q15        = 17'd32768;
    localparam logic [7:0]  DUTY_MAX        = 8'd255;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_MIN_DUTY  = 1'b1;

    typedef enum logic [1:0] {
        OP_DRIVE = 2'd0,
        OP_TEST  = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [7:0] max_speed;
        logic [7:0] min_duty;
    } cfg_t;

    typedef struct packed {
        logic               dead;
        logic               neg;
        logic signed [25:0] prod;
    } mix_t;

    typedef struct packed {
        opcode_t           op;
        logic              arm;
        logic              halt;
        mix_t              left;
        mix_t              right;
        logic signed [8:0] test_left;
        logic signed [8:0] test_right;
        logic [31:0]       duration;
    } item_t;

endpackage

[design/differential_drive_mixer.sv]
// Top level of the two-motor arcade drive mixer.
//
//   channel   direction  group                       contents
//   s_        in         tvalid tready tdata tuser   command or tick
//   m_        out        tvalid tready tdata         motor directions, duties, flags
//   apb       in/out     psel penable pwrite ...     max_drive_speed, min_start_duty
//
// One transaction per cycle sustained while m_ is not stalled; a result shows on m_
// after its input is taken, held in the queue and then the back end's output register.
// The rate is set by the back end, which updates the motor state once per cycle unless m_tready holds its output.
// Reset is synchronous to aclk, active low; speeds, flags and the queue clear,
// registers return to 255 and 80.
// A stalled m_ side fills the queue; s_tready falls once it holds its depth.
`timescale 1ns / 1ps
`include "differential_drive_mixer_macros.svh"

module differential_drive_mixer #(
    parameter int QUEUE_DEPTH = dmx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // throttle[15:0], yaw[31:16], arm_request[32], emergency_halt[33],
    // test_left_speed[44:34], test_right_speed[55:45], test_duration[87:56]
    input  logic [87:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_direction[1:0], left_duty[9:2], right_direction[11:10],
    // right_duty[19:12], test_running[20], armed_flag[21], zero[23:22]
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dmx_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    item_t front_item;
    item_t head_item;
    logic  head_valid;
    logic  pop;
    logic  push;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DUTY) ? {24'd0, cfg_reg.min_duty}
                                                : {24'd0, cfg_reg.max_speed};

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MIN_DUTY) begin
                cfg_next.min_duty = pwdata[7:0];
            end else begin
                cfg_next.max_speed = pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed <= MAX_SPEED_RESET;
            cfg_reg.min_duty  <= MIN_DUTY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign push = s_tvalid && s_tready;

    dmx_front u_front (
        .in_data (s_tdata),
        .in_user (s_tuser),
        .cfg     (cfg_reg),
        .item    (front_item)
    );

    dmx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .push_ready (s_tready),
        .pop_valid  (head_valid),
        .pop_item   (head_item),
        .pop        (pop)
    );

    dmx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .min_duty   (cfg_reg.min_duty),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

    `DDM_ASSERT_IMP(a_stop_duty, aclk, aresetn, m_tvalid,
        ((m_tdata[1:0] == DIR_STOP) == (m_tdata[9:2] == 8'd0)) &&
        ((m_tdata[11:10] == DIR_STOP) == (m_tdata[19:12] == 8'd0)),
        "direction and duty disagree")
    `DDM_ASSERT_IMP(a_dir_code, aclk, aresetn, m_tvalid,
        (m_tdata[1:0] == DIR_STOP || m_tdata[1:0] == DIR_FWD || m_tdata[1:0] == DIR_REV) &&
        (m_tdata[11:10] == DIR_STOP || m_tdata[11:10] == DIR_FWD ||
         m_tdata[11:10] == DIR_REV),
        "bad direction code")
    `DDM_ASSERT_IMP(a_idle_stop, aclk, aresetn, m_tvalid && !m_tdata[20] && !m_tdata[21],
        (m_tdata[1:0] == DIR_STOP) && (m_tdata[11:10] == DIR_STOP),
        "motor running while disarmed without test")

endmodule

[design/dmx_front.sv]
// Front end: decode an input transaction and precompute the mixer products.
`timescale 1ns / 1ps

module dmx_front (
    input  logic [87:0]   in_data,
    input  logic [1:0]    in_user,
    input  dmx_pkg::cfg_t cfg,
    output dmx_pkg::item_t item
);
    import dmx_pkg::*;

    logic signed [15:0] throttle;
    logic signed [15:0] yaw;
    logic signed [10:0] test_left_raw;
    logic signed [10:0] test_right_raw;
    logic signed [8:0]  span;

    function automatic mix_t mix_calc(input logic signed [16:0] sum,
                                      input logic signed [8:0] diff);
        logic [16:0] abs_v;
        logic [15:0] mag;
        mix_t        r;
        abs_v  = sum[16] ? 17'(-sum) : 17'(sum);
        mag    = (abs_v > FULL_Q15) ? FULL_Q15[15:0] : abs_v[15:0];
        r.neg  = sum[16];
        r.dead = (mag <= DEADBAND_Q15);
        r.prod = 26'($signed({1'b0, mag}) * diff);
        return r;
    endfunction

    function automatic logic signed [8:0] sat_test(input logic signed [10:0] v);
        if (v > 11'sd255) begin
            return 9'sd255;
        end else if (v < -11'sd255) begin
            return -9'sd255;
        end else begin
            return v[8:0];
        end
    endfunction

    assign throttle       = in_data[15:0];
    assign yaw            = in_data[31:16];
    assign test_left_raw  = in_data[44:34];
    assign test_right_raw = in_data[55:45];
    assign span           = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_duty});

    always_comb begin
        item.op         = opcode_t'(in_user);
        item.arm        = in_data[32];
        item.halt       = in_data[33];
        item.left       = mix_calc(17'(throttle) + 17'(yaw), span);
        item.right      = mix_calc(17'(throttle) - 17'(yaw), span);
        item.test_left  = sat_test(test_left_raw);
        item.test_right = sat_test(test_right_raw);
        item.duration   = in_data[87:56];
    end

endmodule

[design/dmx_queue.sv]
// Short queue of decoded transactions between front and back end.
`timescale 1ns / 1ps

module dmx_queue #(
    parameter int DEPTH = dmx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dmx_pkg::item_t  push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output dmx_pkg::item_t  pop_item,
    input  logic            pop
);
    import dmx_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/dmx_back.sv]
// Back end: apply a transaction to the motor state and register the result.
`timescale 1ns / 1ps

module dmx_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      min_duty,
    input  logic            head_valid,
    input  dmx_pkg::item_t  head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [23:0]     out_data
);
    import dmx_pkg::*;

    logic signed [8:0] left_speed_reg, left_speed_next;
    logic signed [8:0] right_speed_reg, right_speed_next;
    logic              armed_reg, armed_next;
    logic              test_active_reg, test_active_next;
    logic [31:0]       test_remaining_reg, test_remaining_next;
    logic              out_valid_reg, out_valid_next;
    logic [23:0]       out_data_reg, out_data_next;
    logic [31:0]       remaining_dec;
    logic signed [8:0] left_mapped, right_mapped;

    function automatic logic signed [8:0] map_speed(input mix_t m, input logic [7:0] min_d);
        logic signed [26:0] total;
        logic [11:0]        q;
        logic [7:0]         q8;
        total = $signed({4'b0, min_d, 15'b0}) + 27'(m.prod);
        q     = total[26] ? 12'd0 : total[26:15];
        q8    = (q > 12'(DUTY_MAX)) ? DUTY_MAX : q[7:0];
        if (m.dead) begin
            return 9'sd0;
        end else if (m.neg) begin
            return -$signed({1'b0, q8});
        end else begin
            return $signed({1'b0, q8});
        end
    endfunction

    function automatic logic [9:0] motor_field(input logic signed [8:0] s);
        logic [8:0] a;
        a = s[8] ? 9'(-s) : 9'(s);
        if (s == 9'sd0) begin
            return {8'd0, DIR_STOP};
        end else if (s[8]) begin
            return {a[7:0], DIR_REV};
        end else begin
            return {a[7:0], DIR_FWD};
        end
    endfunction

    assign pop          = head_valid && (!out_valid_reg || out_ready);
    assign left_mapped  = map_speed(head_item.left, min_duty);
    assign right_mapped = map_speed(head_item.right, min_duty);
    assign remaining_dec = (test_remaining_reg == '0) ? '0 : test_remaining_reg - 1'b1;

    always_comb begin
        left_speed_next     = left_speed_reg;
        right_speed_next    = right_speed_reg;
        armed_next          = armed_reg;
        test_active_next    = test_active_reg;
        test_remaining_next = test_remaining_reg;
        if (pop) begin
            case (head_item.op)
                OP_DRIVE: begin
                    armed_next = head_item.arm;
                    if (!test_active_reg) begin
                        if (!head_item.arm || head_item.halt) begin
                            left_speed_next  = '0;
                            right_speed_next = '0;
                        end else begin
                            left_speed_next  = left_mapped;
                            right_speed_next = right_mapped;
                        end
                    end
                end
                OP_TEST: begin
                    test_active_next    = 1'b1;
                    test_remaining_next = head_item.duration;
                    left_speed_next     = head_item.test_left;
                    right_speed_next    = head_item.test_right;
                end
                OP_TICK: begin
                    if (test_active_reg) begin
                        test_remaining_next = remaining_dec;
                        if (remaining_dec == '0) begin
                            test_active_next = 1'b0;
                            left_speed_next  = '0;
                            right_speed_next = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop) begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, armed_next, test_active_next,
                              motor_field(right_speed_next), motor_field(left_speed_next)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_speed_reg     <= '0;
            right_speed_reg    <= '0;
            armed_reg          <= 1'b0;
            test_active_reg    <= 1'b0;
            test_remaining_reg <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            left_speed_reg     <= left_speed_next;
            right_speed_reg    <= right_speed_next;
            armed_reg          <= armed_next;
            test_active_reg    <= test_active_next;
            test_remaining_reg <= test_remaining_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[dv/differential_drive_mixer_tb.sv]
// Self-checking testbench for the differential drive mixer: directed and random commands.
`timescale 1ns / 1ps

module differential_drive_mixer_tb;
    import dmx_pkg::*;

    localparam int          HALF_PERIOD      = 10;
    localparam int          RESET_CYCLES     = 12;
    localparam int          ITEMS_PER_PHASE  = 150;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          WATCHDOG_LIMIT   = 3000;
    localparam int          DRAIN_CYCLES     = 8;
    localparam logic [2:0]  ADDR_MAX_SPEED   = 3'd0;
    localparam logic [2:0]  ADDR_MIN_DUTY    = 3'd4;

    typedef struct packed {
        logic [31:0]        duration;
        logic signed [10:0] test_right;
        logic signed [10:0] test_left;
        logic               halt;
        logic               arm;
        logic signed [15:0] yaw;
        logic signed [15:0] throttle;
    } command_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       armed;
        logic       running;
        logic [7:0] right_duty;
        logic [1:0] right_dir;
        logic [7:0] left_duty;
        logic [1:0] left_dir;
    } motor_word_t;

    class drive_scoreboard;
        logic [7:0]        max_speed;
        logic [7:0]        min_duty;
        logic signed [8:0] left_speed;
        logic signed [8:0] right_speed;
        logic              armed;
        logic              test_on;
        logic [31:0]       ticks_left;
        motor_word_t       expected_words[$];
        int                errors;

        function new();
            max_speed   = MAX_SPEED_RESET;
            min_duty    = MIN_DUTY_RESET;
            left_speed  = '0;
            right_speed = '0;
            armed       = 1'b0;
            test_on     = 1'b0;
            ticks_left  = '0;
            errors      = 0;
        endfunction

        function void set_max_speed(logic [7:0] v);
            max_speed = v;
        endfunction

        function void set_min_duty(logic [7:0] v);
            min_duty = v;
        endfunction

        function logic signed [8:0] duty_from_mix(int mix);
            int     mag;
            longint total;
            if (mix > int'(FULL_Q15))
                mix = int'(FULL_Q15);
            if (mix < -int'(FULL_Q15))
                mix = -int'(FULL_Q15);
            mag = (mix < 0) ? -mix : mix;
            if (mag <= int'(DEADBAND_Q15))
                return '0;
            total = longint'(min_duty) * longint'(FULL_Q15)
                  + longint'(mag) * (longint'(max_speed) - longint'(min_duty));
            if (total < 0)
                total = 0;
            total = total / longint'(FULL_Q15);
            if (total > 255)
                total = 255;
            return (mix < 0) ? -9'(total) : 9'(total);
        endfunction

        function logic signed [8:0] clamp_test_duty(logic signed [10:0] v);
            if (v > 11'sd255)
                return 9'sd255;
            if (v < -11'sd255)
                return -9'sd255;
            return 9'(v);
        endfunction

        function void motor_fields(logic signed [8:0] s, output logic [1:0] dir,
                                   output logic [7:0] duty);
            if (s > 0) begin
                dir  = DIR_FWD;
                duty = 8'(s);
            end else if (s < 0) begin
                dir  = DIR_REV;
                duty = 8'(-s);
            end else begin
                dir  = DIR_STOP;
                duty = '0;
            end
        endfunction

        function void note_command(opcode_t op, command_t c);
            motor_word_t w;
            case (op)
                OP_DRIVE: begin
                    armed = c.arm;
                    if (!test_on) begin
                        if (!armed || c.halt) begin
                            left_speed  = '0;
                            right_speed = '0;
                        end else begin
                            left_speed  = duty_from_mix(int'(c.throttle) + int'(c.yaw));
                            right_speed = duty_from_mix(int'(c.throttle) - int'(c.yaw));
                        end
                    end
                end
                OP_TEST: begin
                    test_on     = 1'b1;
                    ticks_left  = c.duration;
                    left_speed  = clamp_test_duty(c.test_left);
                    right_speed = clamp_test_duty(c.test_right);
                end
                OP_TICK: begin
                    if (test_on) begin
                        if (ticks_left != 0)
                            ticks_left--;
                        if (ticks_left == 0) begin
                            test_on     = 1'b0;
                            left_speed  = '0;
                            right_speed = '0;
                        end
                    end
                end
                default: ;
            endcase
            w = '0;
            motor_fields(left_speed, w.left_dir, w.left_duty);
            motor_fields(right_speed, w.right_dir, w.right_duty);
            w.running = test_on;
            w.armed   = armed;
            expected_words.push_back(w);
        endfunction

        task report(string field, int got, int want);
            errors++;
            $display("%0t mismatch on %s: got %0d, want %0d", $time, field, got, want);
        endtask

        task check_result(logic [23:0] word);
            motor_word_t got;
            motor_word_t want;
            got = motor_word_t'(word);
            if (expected_words.size() == 0) begin
                report("unexpected transaction", int'(word), 0);
                return;
            end
            want = expected_words.pop_front();
            if (got.left_dir != want.left_dir)
                report("left_direction", got.left_dir, want.left_dir);
            if (got.left_duty != want.left_duty)
                report("left_duty", got.left_duty, want.left_duty);
            if (got.right_dir != want.right_dir)
                report("right_direction", got.right_dir, want.right_dir);
            if (got.right_duty != want.right_duty)
                report("right_duty", got.right_duty, want.right_duty);
            if (got.running != want.running)
                report("test_running", got.running, want.running);
            if (got.armed != want.armed)
                report("armed_flag", got.armed, want.armed);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drive_scoreboard sb;
    bit              idle_on      = 1'b1;
    bit              hold_off_req = 1'b0;
    int              quiet_cycles = 0;

    differential_drive_mixer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic command_t make_command(int t, int y, bit arm, bit halt,
                                              int tl, int tr, logic [31:0] dur);
        command_t c;
        c.throttle   = 16'(t);
        c.yaw        = 16'(y);
        c.arm        = arm;
        c.halt       = halt;
        c.test_left  = 11'(tl);
        c.test_right = 11'(tr);
        c.duration   = dur;
        return c;
    endfunction

    function automatic logic [15:0] random_axis();
        case ($urandom_range(7))
            0, 1: return 16'(int'($urandom_range(700)) - 350);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] random_test_duty();
        return $urandom_range(1) ? 11'($urandom) : 11'(int'($urandom_range(600)) - 300);
    endfunction

    function automatic opcode_t random_opcode();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return OP_DRIVE;
        if (pick < 56)
            return OP_TEST;
        return OP_TICK;
    endfunction

    function automatic command_t random_command();
        command_t c;
        c.throttle   = random_axis();
        c.yaw        = random_axis();
        c.arm        = $urandom_range(99) < 85;
        c.halt       = $urandom_range(99) < 12;
        c.test_left  = random_test_duty();
        c.test_right = random_test_duty();
        c.duration   = ($urandom_range(19) == 0) ? 32'($urandom) : 32'($urandom_range(12));
        return c;
    endfunction

    task automatic send(opcode_t op, command_t c);
        if (idle_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_command(op, c);
    endtask

    task automatic write_register(logic [2:0] addr, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic [7:0] max_speed, logic [7:0] min_duty);
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_register(ADDR_MAX_SPEED, max_speed);
        sb.set_max_speed(max_speed);
        write_register(ADDR_MIN_DUTY, min_duty);
        sb.set_min_duty(min_duty);
    endtask

    task automatic run_directed();
        send(OP_DRIVE, make_command(32767, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(32767, 32767, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(-32768, -32768, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(327, 0, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(328, 0, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(-328, -1, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(0, 32767, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(0, -32768, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(32767, -32768, 1'b1, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(20000, 5000, 1'b1, 1'b1, 0, 0, 0));
        send(OP_TEST, make_command(0, 0, 1'b0, 1'b0, 1023, -1024, 32'd2));
        send(OP_DRIVE, make_command(32767, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(-32768, 0, 1'b1, 1'b0, 0, 0, 0));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_TEST, make_command(0, 0, 1'b0, 1'b0, -255, 255, 32'd0));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_TEST, make_command(0, 0, 1'b0, 1'b0, 256, -256, 32'hFFFF_FFFF));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_TEST, make_command(0, 0, 1'b0, 1'b0, 100, -1, 32'd1));
        send(OP_TICK, make_command(0, 0, 1'b0, 1'b0, 0, 0, 0));
        send(OP_DRIVE, make_command(-1000, 30000, 1'b1, 1'b0, 0, 0, 0));
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send(random_opcode(), random_command());
    endtask

    initial begin : result_sink
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= !idle_on || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        apply_setting(8'd255, 8'd0);
        run_random(20);
        hold_off_req = 1'b1;
        run_random(ITEMS_PER_PHASE - 20);

        apply_setting(8'd0, 8'd0);
        run_random(ITEMS_PER_PHASE);

        apply_setting(8'd255, 8'd255);
        idle_on = 1'b0;
        run_random(ITEMS_PER_PHASE);
        idle_on = 1'b1;

        apply_setting(8'd0, 8'd255);
        run_random(ITEMS_PER_PHASE);

        apply_setting(8'd200, 8'd40);
        run_random(ITEMS_PER_PHASE);

        apply_setting(8'($urandom), 8'($urandom));
        run_random(ITEMS_PER_PHASE);

        apply_setting(MAX_SPEED_RESET, MIN_DUTY_RESET);
        run_random(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/dmx_pkg.sv
design/dmx_front.sv
design/dmx_queue.sv
design/dmx_back.sv
design/differential_drive_mixer.sv
dv/differential_drive_mixer_tb.sv
